>>> hdl/nonpreemptive_job_scheduler_top_macros.svh
// assertion macros used by the port-level checker
`ifndef NONPREEMPTIVE_JOB_SCHEDULER_TOP_MACROS_SVH
`define NONPREEMPTIVE_JOB_SCHEDULER_TOP_MACROS_SVH

// implication checked every clock outside reset
`define NJS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define NJS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/njs_pkg.sv
// package for the job scheduler: widths, codes and states
`timescale 1ns / 1ps
package njs_pkg;
  localparam int MaxJobsDef = 32;
  localparam int TickW = 23;
  localparam int WtW = 30;
  localparam int TsumW = 27;
  localparam int WsumW = 35;
  localparam int DivW = TickW + 8;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF = 2'd1;
  localparam logic [1:0] POL_HRRN = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN_RD,
    ST_MIN_CHK,
    ST_SEL_RD,
    ST_SEL_CHK,
    ST_MUL,
    ST_CMP,
    ST_DISP,
    ST_DIV,
    ST_OUT
  } state_t;
endpackage

>>> hdl/nonpreemptive_job_scheduler_top.sv
// job scheduler top level: job table memory and dispatch sequencer
//
// channel | dir | handshake      | payload
// in_     | in  | valid / stall  | op, job_id, arrival_time, service_time
// out_    | out | valid / stall  | sched_job_id .. last
// cfg_    | in  | valid / ready  | policy_mode
//
// a run gives one word per job
// each dispatch walks the table twice through the single read port, once for
// the earliest arrival and once to select (with a multiply and a compare step
// per candidate for hrrn), then takes a dispatch step, a restoring divide and
// an output step
// reset is synchronous and clears the table count, policy and sequencer
// a stalled result word holds; no new item is taken during a run or while a word waits
`timescale 1ns / 1ps
module nonpreemptive_job_scheduler_top #(
  parameter int MAX_JOBS = njs_pkg::MaxJobsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [7:0]                in_job_id,
  input  logic [15:0]               in_arrival_time,
  input  logic [15:0]               in_service_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_sched_job_id,
  output logic [njs_pkg::TickW-1:0] out_start_tick,
  output logic [njs_pkg::TickW-1:0] out_finish_tick,
  output logic [njs_pkg::TickW-1:0] out_turnaround,
  output logic [njs_pkg::WtW-1:0]   out_weighted_turnaround,
  output logic [njs_pkg::TsumW-1:0] out_turnaround_sum,
  output logic [njs_pkg::WsumW-1:0] out_weighted_sum,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_policy_mode
);
  localparam int IdxW = $clog2(MAX_JOBS);
  localparam int CntW = $clog2(MAX_JOBS + 1);
  localparam int TickW = njs_pkg::TickW;
  localparam int DivW = njs_pkg::DivW;
  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // job table memory: id, arrival, service
  logic [39:0] mem [MAX_JOBS];
  logic [39:0] rd_q;
  logic [IdxW-1:0] rd_addr;
  logic wr_en;

  logic [1:0] policy_r;
  logic [CntW-1:0] count_r;
  logic [MAX_JOBS-1:0] done_r;
  logic [TickW-1:0] tick_r;
  njs_pkg::state_t st_r, st_nxt;
  logic [CntW-1:0] scan_r;     // scan position, may reach count
  logic [CntW-1:0] ndisp_r;    // jobs dispatched so far
  logic [16:0] earliest_r;     // bit 16 marks none found
  logic have_r;
  logic [IdxW-1:0] pick_r;
  logic [15:0] p_arr_r, p_svc_r;
  logic [7:0] p_id_r;
  logic [15:0] c_arr_r, c_svc_r;
  logic [IdxW-1:0] c_idx_r;
  logic [7:0] c_id_r;
  logic c_ok_r;
  logic [40:0] ra_r, rb_r;
  logic [DivW-1:0] quo_r;
  logic [16:0] rem_r;
  logic [5:0] dcnt_r;
  logic [TickW-1:0] ta_r;
  logic [TickW-1:0] start_r;
  logic [njs_pkg::TsumW:0] tsum_w;
  logic [njs_pkg::WsumW:0] wsum_w;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != njs_pkg::ST_IDLE) || out_valid;
  assign cfg_ready = !in_stall;
  assign wr_en = in_acc && in_op == njs_pkg::OP_LOAD && count_r < CntW'(MAX_JOBS);
  logic [IdxW-1:0] scan_idx;
  assign scan_idx = scan_r[IdxW-1:0];
  assign rd_addr = scan_idx;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IdxW-1:0]] <= {in_job_id, in_arrival_time,
        (in_service_time == 16'd0) ? 16'd1 : in_service_time};
    end
    rd_q <= mem[rd_addr];
  end

  // candidate fields
  logic [15:0] q_arr, q_svc;
  assign q_arr = rd_q[31:16];
  assign q_svc = rd_q[15:0];
  logic [IdxW-1:0] q_idx_r;   // index that rd_q belongs to
  logic q_done;
  assign q_done = done_r[q_idx_r];
  logic scan_end;
  assign scan_end = (scan_r == count_r);

  // tie rule for the hrrn ratio compare: earlier arrival, then lower index
  logic tie_better;
  assign tie_better = (c_arr_r != p_arr_r) ? (c_arr_r < p_arr_r) : (c_idx_r < pick_r);

  // wait plus service of candidate and current pick
  logic [TickW-1:0] c_rsp, p_rsp;
  assign c_rsp = tick_r - {7'b0, c_arr_r} + {7'b0, c_svc_r};
  assign p_rsp = tick_r - {7'b0, p_arr_r} + {7'b0, p_svc_r};

  logic [TickW-1:0] fin_w;
  logic [TickW:0] fin_sum;
  assign fin_sum = {1'b0, tick_r} + (TickW+1)'(p_svc_r);
  assign fin_w = fin_sum[TickW] ? TickMax : fin_sum[TickW-1:0];

  // divider step: restoring, one quotient bit per cycle
  logic [17:0] rem_sh;
  logic [17:0] rem_sub;
  assign rem_sh = {rem_r, quo_r[DivW-1]};
  assign rem_sub = rem_sh - {2'b0, p_svc_r};

  logic [DivW-1:0] wt_w;
  assign wt_w = quo_r;
  logic [njs_pkg::WtW-1:0] wt_sat;
  assign wt_sat = (|wt_w[DivW-1:njs_pkg::WtW]) ? {njs_pkg::WtW{1'b1}}
                                                : wt_w[njs_pkg::WtW-1:0];
  assign tsum_w = {1'b0, out_turnaround_sum} + (njs_pkg::TsumW+1)'(ta_r);
  assign wsum_w = {1'b0, out_weighted_sum} + (njs_pkg::WsumW+1)'(wt_sat);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      njs_pkg::ST_IDLE:
        if (in_acc && in_op == njs_pkg::OP_RUN && count_r != '0) st_nxt = njs_pkg::ST_MIN_RD;
      njs_pkg::ST_MIN_RD: st_nxt = njs_pkg::ST_MIN_CHK;
      njs_pkg::ST_MIN_CHK: st_nxt = scan_end ? njs_pkg::ST_SEL_RD : njs_pkg::ST_MIN_RD;
      njs_pkg::ST_SEL_RD: st_nxt = scan_end ? njs_pkg::ST_DISP : njs_pkg::ST_SEL_CHK;
      njs_pkg::ST_SEL_CHK: st_nxt = (policy_r == njs_pkg::POL_HRRN) ? njs_pkg::ST_MUL
                                                               : njs_pkg::ST_SEL_RD;
      njs_pkg::ST_MUL: st_nxt = njs_pkg::ST_CMP;
      njs_pkg::ST_CMP: st_nxt = njs_pkg::ST_SEL_RD;
      njs_pkg::ST_DISP: st_nxt = njs_pkg::ST_DIV;
      njs_pkg::ST_DIV: st_nxt = (dcnt_r == 6'(DivW - 1)) ? njs_pkg::ST_OUT : njs_pkg::ST_DIV;
      njs_pkg::ST_OUT:
        if (!out_valid) begin
          st_nxt = (ndisp_r + CntW'(1) == count_r) ? njs_pkg::ST_IDLE : njs_pkg::ST_MIN_RD;
        end
      default: st_nxt = njs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= njs_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  // selection of the candidate read this cycle
  logic cand_ok;
  assign cand_ok = !q_done && ({7'b0, q_arr} <= tick_r);

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= njs_pkg::POL_FCFS;
      count_r <= '0;
      done_r <= '0;
      tick_r <= '0;
      out_valid <= 1'b0;
      scan_r <= '0;
      ndisp_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) policy_r <= cfg_policy_mode;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      q_idx_r <= scan_idx;
      unique case (st_r)
        njs_pkg::ST_IDLE: begin
          if (wr_en) count_r <= count_r + CntW'(1);
          if (in_acc && in_op == njs_pkg::OP_CLEAR) begin
            count_r <= '0;
            done_r <= '0;
            tick_r <= '0;
          end
          if (in_acc && in_op == njs_pkg::OP_RUN) begin
            done_r <= '0;
            tick_r <= '0;
            ndisp_r <= '0;
            out_turnaround_sum <= '0;
            out_weighted_sum <= '0;
          end
          scan_r <= '0;
          earliest_r <= 17'h10000;
        end
        njs_pkg::ST_MIN_RD: scan_r <= scan_r + CntW'(1);
        njs_pkg::ST_MIN_CHK: begin
          // earliest pending arrival, then idle forward
          if (!q_done && {1'b0, q_arr} < earliest_r) earliest_r <= {1'b0, q_arr};
          if (scan_end) begin
            scan_r <= '0;
            have_r <= 1'b0;
            if (!q_done && {1'b0, q_arr} < earliest_r) begin
              if ({7'b0, q_arr} > tick_r) tick_r <= {7'b0, q_arr};
            end else if (!earliest_r[16] && {7'b0, earliest_r[15:0]} > tick_r) begin
              tick_r <= {7'b0, earliest_r[15:0]};
            end
          end
        end
        njs_pkg::ST_SEL_RD: begin
          if (!scan_end) scan_r <= scan_r + CntW'(1);
        end
        njs_pkg::ST_SEL_CHK: begin
          c_arr_r <= q_arr;
          c_svc_r <= q_svc;
          c_idx_r <= q_idx_r;
          if (policy_r != njs_pkg::POL_HRRN && cand_ok) begin
            if (!have_r ||
                ((policy_r == njs_pkg::POL_SJF && q_svc != p_svc_r) ? (q_svc < p_svc_r) :
                 ((q_arr != p_arr_r) ? (q_arr < p_arr_r) : (q_idx_r < pick_r)))) begin
              have_r <= 1'b1;
              pick_r <= q_idx_r;
              p_arr_r <= q_arr;
              p_svc_r <= q_svc;
              p_id_r <= rd_q[39:32];
            end
          end
          if (policy_r == njs_pkg::POL_HRRN && cand_ok && !have_r) begin
            have_r <= 1'b1;
            pick_r <= q_idx_r;
            p_arr_r <= q_arr;
            p_svc_r <= q_svc;
            p_id_r <= rd_q[39:32];
          end
          c_id_r <= rd_q[39:32];
          c_ok_r <= cand_ok && have_r;
        end
        njs_pkg::ST_MUL: begin
          // cross products of wait+service against the other service
          ra_r <= {18'b0, c_rsp} * {25'b0, p_svc_r};
          rb_r <= {18'b0, p_rsp} * {25'b0, c_svc_r};
        end
        njs_pkg::ST_CMP: begin
          if (c_ok_r && ((ra_r != rb_r) ? (ra_r > rb_r) : tie_better)) begin
            pick_r <= c_idx_r;
            p_arr_r <= c_arr_r;
            p_svc_r <= c_svc_r;
            p_id_r <= c_id_r;
          end
        end
        njs_pkg::ST_DISP: begin
          done_r[pick_r] <= 1'b1;
          start_r <= tick_r;
          tick_r <= fin_w;
          ta_r <= fin_w - {7'b0, p_arr_r};
          quo_r <= {fin_w - {7'b0, p_arr_r}, 8'b0};
          rem_r <= '0;
          dcnt_r <= '0;
        end
        njs_pkg::ST_DIV: begin
          dcnt_r <= dcnt_r + 6'd1;
          if (!rem_sub[17]) begin
            rem_r <= rem_sub[16:0];
            quo_r <= {quo_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[16:0];
            quo_r <= {quo_r[DivW-2:0], 1'b0};
          end
        end
        njs_pkg::ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_sched_job_id <= p_id_r;
            out_start_tick <= start_r;
            out_finish_tick <= tick_r;
            out_turnaround <= ta_r;
            out_weighted_turnaround <= wt_sat;
            out_turnaround_sum <= tsum_w[njs_pkg::TsumW] ? {njs_pkg::TsumW{1'b1}}
                                                         : tsum_w[njs_pkg::TsumW-1:0];
            out_weighted_sum <= wsum_w[njs_pkg::WsumW] ? {njs_pkg::WsumW{1'b1}}
                                                       : wsum_w[njs_pkg::WsumW-1:0];
            out_last <= (ndisp_r + CntW'(1) == count_r);
            ndisp_r <= ndisp_r + CntW'(1);
            scan_r <= '0;
            earliest_r <= 17'h10000;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/njs_checker.sv
// port-level checker for the job scheduler, bound to the top level
`timescale 1ns / 1ps
`include "nonpreemptive_job_scheduler_top_macros.svh"
module njs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_sched_job_id,
  input logic       cfg_ready
);
  // held word stays on a stall
  `NJS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sched_job_id), "word changed while stalled")
  // config only taken while input side is open
  `NJS_ASSERT_IMP(a_cfg, clk, rst_n, cfg_ready, !in_stall, "config ready during a run")
  // results only while inputs are blocked
  `NJS_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall, "input open while a word waits")
endmodule

bind nonpreemptive_job_scheduler_top njs_checker u_njs_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_sched_job_id(out_sched_job_id), .cfg_ready(cfg_ready)
);

>>> verif/njs_schedule_checker.sv
// checker for the job scheduler: table predictor and result scoreboard
`timescale 1ns / 1ps
module njs_schedule_checker #(
  parameter int MAX_JOBS = njs_pkg::MaxJobsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [7:0]                        in_job_id,
  input  logic [15:0]                       in_arrival_time,
  input  logic [15:0]                       in_service_time,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [7:0]                        out_sched_job_id,
  input  logic [njs_pkg::TickW-1:0]         out_start_tick,
  input  logic [njs_pkg::TickW-1:0]         out_finish_tick,
  input  logic [njs_pkg::TickW-1:0]         out_turnaround,
  input  logic [njs_pkg::WtW-1:0]           out_weighted_turnaround,
  input  logic [njs_pkg::TsumW-1:0]         out_turnaround_sum,
  input  logic [njs_pkg::WsumW-1:0]         out_weighted_sum,
  input  logic                              out_last,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [1:0]                        cfg_policy_mode,
  output int                                fail_count,
  output int                                pending,
  output int                                words_checked
);
  localparam int TickW = njs_pkg::TickW;
  localparam int WtW   = njs_pkg::WtW;
  localparam int TsumW = njs_pkg::TsumW;
  localparam int WsumW = njs_pkg::WsumW;

  localparam longint unsigned TickMax = (64'd1 << TickW) - 1;
  localparam longint unsigned WtMax   = (64'd1 << WtW) - 1;
  localparam longint unsigned TsumMax = (64'd1 << TsumW) - 1;
  localparam longint unsigned WsumMax = (64'd1 << WsumW) - 1;

  typedef struct packed {
    logic [7:0]       job_id;
    logic [TickW-1:0] start;
    logic [TickW-1:0] finish;
    logic [TickW-1:0] turnaround;
    logic [WtW-1:0]   weighted;
    logic [TsumW-1:0] ta_sum;
    logic [WsumW-1:0] wt_sum;
    logic             last;
  } dispatch_t;

  // model copy of the job table and policy
  logic [15:0] job_arrival [MAX_JOBS];
  logic [15:0] job_service [MAX_JOBS];
  logic [7:0]  job_ident   [MAX_JOBS];
  int          job_total;
  logic [1:0]  policy;

  dispatch_t sched_expected[$];

  assign pending = sched_expected.size();

  // true when job a wins over job b at tick t
  function automatic bit job_wins(int a, int b, longint unsigned t);
    longint unsigned sa, sb, aa, ab, ra, rb;
    sa = job_service[a];
    sb = job_service[b];
    aa = job_arrival[a];
    ab = job_arrival[b];
    if (policy == njs_pkg::POL_SJF) begin
      if (sa != sb) return sa < sb;
    end else if (policy == njs_pkg::POL_HRRN) begin
      ra = (t - aa + sa) * sb;
      rb = (t - ab + sb) * sa;
      if (ra != rb) return ra > rb;
    end
    if (aa != ab) return aa < ab;
    return a < b;
  endfunction

  // build the whole dispatch order of the table
  task automatic compute_schedule();
    bit              done [MAX_JOBS];
    longint unsigned tick, earliest, fin, ta, wt, tsum, wsum;
    int              pick;
    bit              have;
    dispatch_t       d;
    tick = 0;
    tsum = 0;
    wsum = 0;
    for (int i = 0; i < MAX_JOBS; i++) done[i] = 1'b0;
    for (int n = 0; n < job_total; n++) begin
      earliest = 64'hFFFF_FFFF;
      for (int i = 0; i < job_total; i++)
        if (!done[i] && job_arrival[i] < earliest) earliest = job_arrival[i];
      if (earliest > tick) tick = earliest;
      have = 1'b0;
      pick = 0;
      for (int i = 0; i < job_total; i++) begin
        if (done[i] || job_arrival[i] > tick) continue;
        if (!have || job_wins(i, pick, tick)) begin
          pick = i;
          have = 1'b1;
        end
      end
      done[pick] = 1'b1;
      fin = tick + job_service[pick];
      if (fin > TickMax) fin = TickMax;
      ta = fin - job_arrival[pick];
      wt = (ta << 8) / job_service[pick];
      if (wt > WtMax) wt = WtMax;
      tsum += ta;
      if (tsum > TsumMax) tsum = TsumMax;
      wsum += wt;
      if (wsum > WsumMax) wsum = WsumMax;
      d.job_id     = job_ident[pick];
      d.start      = tick[TickW-1:0];
      d.finish     = fin[TickW-1:0];
      d.turnaround = ta[TickW-1:0];
      d.weighted   = wt[WtW-1:0];
      d.ta_sum     = tsum[TsumW-1:0];
      d.wt_sum     = wsum[WsumW-1:0];
      d.last       = (n + 1 == job_total);
      sched_expected.push_back(d);
      tick = fin;
    end
  endtask

  // one field comparison with report
  task automatic cmp_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  dispatch_t got, exp_d;

  always @(posedge clk) begin
    if (!rst_n) begin
      job_total     = 0;
      policy        = njs_pkg::POL_FCFS;
      fail_count    = 0;
      words_checked = 0;
      sched_expected.delete();
    end else begin
      // policy register write
      if (cfg_valid && cfg_ready) policy = cfg_policy_mode;

      // result word against oldest expectation
      if (out_valid && !out_stall) begin
        got = '{out_sched_job_id, out_start_tick, out_finish_tick, out_turnaround,
                out_weighted_turnaround, out_turnaround_sum, out_weighted_sum,
                out_last};
        words_checked++;
        if (sched_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, job id %0d", $time, out_sched_job_id);
        end else begin
          exp_d = sched_expected.pop_front();
          cmp_field("sched_job_id", exp_d.job_id, got.job_id);
          cmp_field("start_tick", exp_d.start, got.start);
          cmp_field("finish_tick", exp_d.finish, got.finish);
          cmp_field("turnaround", exp_d.turnaround, got.turnaround);
          cmp_field("weighted_turnaround", exp_d.weighted, got.weighted);
          cmp_field("turnaround_sum", exp_d.ta_sum, got.ta_sum);
          cmp_field("weighted_sum", exp_d.wt_sum, got.wt_sum);
          cmp_field("last", exp_d.last, got.last);
        end
      end

      // accepted input word
      if (in_valid && !in_stall) begin
        case (in_op)
          njs_pkg::OP_LOAD: begin
            if (job_total < MAX_JOBS) begin
              job_ident[job_total]   = in_job_id;
              job_arrival[job_total] = in_arrival_time;
              job_service[job_total] = (in_service_time == 16'd0) ? 16'd1 : in_service_time;
              job_total = job_total + 1;
            end
          end
          njs_pkg::OP_RUN:   compute_schedule();
          njs_pkg::OP_CLEAR: job_total = 0;
          default: ;
        endcase
      end
    end
  end
endmodule

>>> verif/tb.sv
// testbench top for the job scheduler: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module tb;
  localparam logic [1:0] OpIgnored = 2'd3;
  localparam logic [1:0] PolSpare = 2'd3;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   in_op;
  logic [7:0]                   in_job_id;
  logic [15:0]                  in_arrival_time;
  logic [15:0]                  in_service_time;
  logic                         out_valid;
  logic                         out_stall;
  logic [7:0]                   out_sched_job_id;
  logic [njs_pkg::TickW-1:0]    out_start_tick;
  logic [njs_pkg::TickW-1:0]    out_finish_tick;
  logic [njs_pkg::TickW-1:0]    out_turnaround;
  logic [njs_pkg::WtW-1:0]      out_weighted_turnaround;
  logic [njs_pkg::TsumW-1:0]    out_turnaround_sum;
  logic [njs_pkg::WsumW-1:0]    out_weighted_sum;
  logic                         out_last;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [1:0]                   cfg_policy_mode;

  int fail_count;
  int pending;
  int words_checked;
  int words_sent;
  int runs_sent;
  bit stall_quiet;

  nonpreemptive_job_scheduler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_job_id(in_job_id),
    .in_arrival_time(in_arrival_time), .in_service_time(in_service_time),
    .out_valid(out_valid), .out_stall(out_stall), .out_sched_job_id(out_sched_job_id),
    .out_start_tick(out_start_tick), .out_finish_tick(out_finish_tick),
    .out_turnaround(out_turnaround), .out_weighted_turnaround(out_weighted_turnaround),
    .out_turnaround_sum(out_turnaround_sum), .out_weighted_sum(out_weighted_sum),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_policy_mode(cfg_policy_mode)
  );

  njs_schedule_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_job_id(in_job_id),
    .in_arrival_time(in_arrival_time), .in_service_time(in_service_time),
    .out_valid(out_valid), .out_stall(out_stall), .out_sched_job_id(out_sched_job_id),
    .out_start_tick(out_start_tick), .out_finish_tick(out_finish_tick),
    .out_turnaround(out_turnaround), .out_weighted_turnaround(out_weighted_turnaround),
    .out_turnaround_sum(out_turnaround_sum), .out_weighted_sum(out_weighted_sum),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_policy_mode(cfg_policy_mode),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // result side back-pressure, with quiet stretches
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!stall_quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run watchdog
  initial begin
    #20_000_000;
    $display("nonpreemptive_job_scheduler_top test failed");
    $finish;
  end

  // one input word, with a random gap first; called just after a rising edge
  task automatic send_word(input logic [1:0] op, input logic [7:0] id,
                           input logic [15:0] arr, input logic [15:0] svc);
    int gap;
    bit took;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_job_id       <= id;
    in_arrival_time <= arr;
    in_service_time <= svc;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    words_sent++;
    if (op == njs_pkg::OP_RUN) runs_sent++;
  endtask

  // drain all expected words, let the block settle, then write the policy
  task automatic set_policy(input logic [1:0] mode);
    bit took;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_policy_mode <= mode;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  // random job with mostly small, clustered values
  task automatic load_random(input bit wide);
    logic [15:0] arr, svc;
    arr = wide ? 16'($urandom) : 16'($urandom_range(0, 40));
    svc = wide ? 16'($urandom) : 16'($urandom_range(0, 12));
    send_word(njs_pkg::OP_LOAD, 8'($urandom), arr, svc);
  endtask

  int n_jobs;
  logic [1:0] mode;

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = njs_pkg::OP_LOAD;
    in_job_id       = '0;
    in_arrival_time = '0;
    in_service_time = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_policy_mode = njs_pkg::POL_FCFS;
    stall_left      = 0;
    stall_quiet     = 1'b0;
    words_sent      = 0;
    runs_sent       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero service, ignored op, empty run, ties
    set_policy(njs_pkg::POL_FCFS);
    send_word(njs_pkg::OP_LOAD, 8'd0, 16'd0, 16'd0);
    send_word(njs_pkg::OP_LOAD, 8'd255, 16'hFFFF, 16'hFFFF);
    send_word(njs_pkg::OP_LOAD, 8'd7, 16'd3, 16'd5);
    send_word(OpIgnored, 8'hAA, 16'h5555, 16'hAAAA);
    send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
    send_word(njs_pkg::OP_CLEAR, 8'd0, 16'd0, 16'd0);
    send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
    send_word(njs_pkg::OP_LOAD, 8'd10, 16'd2, 16'd4);
    send_word(njs_pkg::OP_LOAD, 8'd11, 16'd2, 16'd4);
    send_word(njs_pkg::OP_LOAD, 8'd12, 16'd0, 16'd9);
    send_word(njs_pkg::OP_LOAD, 8'd13, 16'd1, 16'd1);
    send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
    set_policy(njs_pkg::POL_SJF);
    send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
    set_policy(njs_pkg::POL_HRRN);
    send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
    set_policy(PolSpare);
    send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
    send_word(njs_pkg::OP_CLEAR, 8'd0, 16'd0, 16'd0);

    // random job sets, one overfilled table, policies cycled
    for (int s = 0; s < 10; s++) begin
      mode = (s < 4) ? 2'(s) : 2'($urandom_range(0, 3));
      set_policy(mode);
      stall_quiet = (s % 5 == 2);
      n_jobs = (s == 3) ? 34 : $urandom_range(1, 6);
      for (int j = 0; j < n_jobs; j++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_word(OpIgnored, 8'($urandom), 16'($urandom), 16'($urandom));
        end
        load_random(s == 3 || $urandom_range(0, 4) == 0);
      end
      send_word(njs_pkg::OP_RUN, 8'($urandom), 16'($urandom), 16'($urandom));
      // rerun the kept table under another policy now and then
      if ($urandom_range(0, 2) == 0) begin
        set_policy(2'($urandom_range(0, 3)));
        send_word(njs_pkg::OP_RUN, 8'd0, 16'd0, 16'd0);
      end
      send_word(njs_pkg::OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
    end
    stall_quiet = 1'b0;

    // drain and settle
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);

    $display("sent %0d input words including %0d runs, checked %0d schedule words",
             words_sent, runs_sent, words_checked);
    $display("covered all policies, overfilled table, zero service, ignored op, empty run");
    if (fail_count == 0 && pending == 0) begin
      $display("nonpreemptive_job_scheduler_top test passed");
    end else begin
      $display("nonpreemptive_job_scheduler_top test failed");
    end
    $finish;
  end
endmodule

>>> nonpreemptive_job_scheduler_top.f
+incdir+hdl
hdl/njs_pkg.sv
hdl/nonpreemptive_job_scheduler_top.sv
hdl/njs_checker.sv
verif/njs_schedule_checker.sv
verif/tb.sv
